[rtl/gbs_pkg.sv]
// Package for the greedy box suppression block: field widths, register reset value
// and result bit positions. It has no dependencies.
package gbs_pkg;

    localparam int FIELD_W    = 16;     // width of one coordinate field on the port
    localparam int THR_W      = 17;     // IoU threshold, unsigned Q1.16
    localparam int FRAC_W     = 16;     // fraction bits of the threshold
    localparam int INDEX_W    = 10;     // box_index field
    localparam int TOTAL_W    = 11;     // kept_total field
    localparam int POS_W      = 32;     // saturating position counter
    localparam int IN_DATA_W  = 64;     // four coordinates
    localparam int OUT_DATA_W = 24;     // 23 result bits, padded to whole bytes

    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    // result word layout, lowest bit up
    localparam int OUT_INDEX_LSB = 0;
    localparam int OUT_KEEP_BIT  = 10;
    localparam int OUT_TOTAL_LSB = 11;
    localparam int OUT_OVF_BIT   = 22;

endpackage

[rtl/greedy_box_suppression.sv]
// Top level of the greedy IoU box suppression block: sequencer, shared multiplier
// and result register. Depends on gbs_pkg and gbs_ram (kept-box store).
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata = x1,y1,x2,y2; tlast = set end
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata = index,keep,total,ovf; tlast
//   cfg       in   cfg_wr_en (no wait)            cfg_wr_data = iou_threshold
//
// Sequence: an accepted item passes S_AREA and S_AREA_W, then for each of the K kept
// boxes compared six steps (S_RD to S_CMP) on the one shared multiplier, then S_FIN and
// S_OUT, where the result register is loaded; an overflow box goes straight to S_FIN.
// Reset clears the counters and loads the threshold reset value; the store needs no clearing pass, since only
// entries below the kept count are ever read.
// Stalls: the sequencer holds at its last step only while the output register holds a result not being taken.
module greedy_box_suppression #(
    parameter int MAX_BOXES  = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // fields from bit 0 up: left_x[15:0], top_y[31:16], right_x[47:32], bottom_y[63:48]
    input  logic [gbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // fields from bit 0 up: box_index[9:0], keep[10], kept_total[21:11], overflow[22],
    // zero pad[23]
    output logic [gbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]        cfg_wr_data
);

    // Coordinates used: low COORD_BITS of each 16-bit field.
    localparam int CW    = (COORD_BITS < gbs_pkg::FIELD_W) ? COORD_BITS : gbs_pkg::FIELD_W;
    localparam int IW    = 2 * CW;                   // areas and intersection
    localparam int MA    = IW + 1;                   // union, multiplier operand A
    localparam int PW    = MA + gbs_pkg::THR_W;      // multiplier product
    localparam int AW    = $clog2(MAX_BOXES);        // store address
    localparam int CNT_W = $clog2(MAX_BOXES + 1);    // kept count, 0..MAX_BOXES
    localparam int BW    = 4 * CW;                   // one stored box

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_AREA   = 11'b00000000010,
        S_AREA_W = 11'b00000000100,
        S_RD     = 11'b00000001000,
        S_INT    = 11'b00000010000,
        S_KAREA  = 11'b00000100000,
        S_UNION  = 11'b00001000000,
        S_THR    = 11'b00010000000,
        S_CMP    = 11'b00100000000,
        S_FIN    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    function automatic logic [CW-1:0] side_len(input logic [CW-1:0] lo,
                                               input logic [CW-1:0] hi);
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

    // control registers
    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            kept_count_reg, kept_count_next;
    logic [gbs_pkg::POS_W-1:0]   next_position_reg, next_position_next;
    logic [gbs_pkg::THR_W-1:0]   thr_reg, thr_next;
    logic                        m_valid_reg, m_valid_next;

    // payload registers
    logic [CW-1:0]               bx1_reg, by1_reg, bx2_reg, by2_reg;
    logic [CW-1:0]               bx1_next, by1_next, bx2_next, by2_next;
    logic                        last_reg, last_next;
    logic                        ovf_reg, ovf_next;
    logic                        keep_reg, keep_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [PW-1:0]               prod_reg, prod_next;
    logic [IW-1:0]               area_n_reg, area_n_next;
    logic [IW-1:0]               inter_reg, inter_next;
    logic [MA-1:0]               union_reg, union_next;
    logic [gbs_pkg::INDEX_W-1:0] res_index_reg, res_index_next;
    logic [gbs_pkg::TOTAL_W-1:0] res_total_reg, res_total_next;
    logic [gbs_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    // shared multiplier
    logic [MA-1:0]               mul_a;
    logic [gbs_pkg::THR_W-1:0]   mul_b;
    logic [PW-1:0]               mul_prod;

    // store
    logic                        ram_wr_en, ram_rd_en;
    logic [BW-1:0]               ram_rd_data;
    logic [CW-1:0]               kx1, ky1, kx2, ky2;
    logic [CW-1:0]               iw, ih, kw, kh, nw, nh;
    logic [PW-1:0]               cmp_lhs;
    logic                        over_thr, in_accept, out_free;

    assign kx1 = ram_rd_data[CW-1:0];
    assign ky1 = ram_rd_data[2*CW-1:CW];
    assign kx2 = ram_rd_data[3*CW-1:2*CW];
    assign ky2 = ram_rd_data[4*CW-1:3*CW];

    // intersection sides: max of the low edges, min of the high edges
    assign iw = side_len((kx1 > bx1_reg) ? kx1 : bx1_reg, (kx2 < bx2_reg) ? kx2 : bx2_reg);
    assign ih = side_len((ky1 > by1_reg) ? ky1 : by1_reg, (ky2 < by2_reg) ? ky2 : by2_reg);
    assign kw = side_len(kx1, kx2);
    assign kh = side_len(ky1, ky2);
    assign nw = side_len(bx1_reg, bx2_reg);
    assign nh = side_len(by1_reg, by2_reg);

    assign mul_prod = mul_a * mul_b;

    // inter * 2^16 against threshold * union
    assign cmp_lhs  = PW'({inter_reg, gbs_pkg::FRAC_W'(0)});
    assign over_thr = cmp_lhs > prod_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign ram_rd_en = (state_reg == S_RD);
    assign ram_wr_en = (state_reg == S_FIN) && keep_reg;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    gbs_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (kept_count_reg[AW-1:0]),
        .wr_data ({by2_reg, bx2_reg, by1_reg, bx1_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_AREA: begin
                mul_a = MA'(nw);
                mul_b = gbs_pkg::THR_W'(nh);
            end
            S_INT: begin
                mul_a = MA'(iw);
                mul_b = gbs_pkg::THR_W'(ih);
            end
            S_KAREA: begin
                mul_a = MA'(kw);
                mul_b = gbs_pkg::THR_W'(kh);
            end
            S_THR: begin
                mul_a = union_reg;
                mul_b = thr_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next         = state_reg;
        kept_count_next    = kept_count_reg;
        next_position_next = next_position_reg;
        thr_next           = cfg_wr_en ? cfg_wr_data : thr_reg;
        m_valid_next       = m_valid_reg;
        bx1_next           = bx1_reg;
        by1_next           = by1_reg;
        bx2_next           = bx2_reg;
        by2_next           = by2_reg;
        last_next          = last_reg;
        ovf_next           = ovf_reg;
        keep_next          = keep_reg;
        idx_next           = idx_reg;
        prod_next          = prod_reg;
        area_n_next        = area_n_reg;
        inter_next         = inter_reg;
        union_next         = union_reg;
        res_index_next     = res_index_reg;
        res_total_next     = res_total_reg;
        m_data_next        = m_data_reg;
        m_last_next        = m_last_reg;

        // drop the result once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    bx1_next  = s_axis_tdata[CW-1:0];
                    by1_next  = s_axis_tdata[gbs_pkg::FIELD_W+CW-1:gbs_pkg::FIELD_W];
                    bx2_next  = s_axis_tdata[2*gbs_pkg::FIELD_W+CW-1:2*gbs_pkg::FIELD_W];
                    by2_next  = s_axis_tdata[3*gbs_pkg::FIELD_W+CW-1:3*gbs_pkg::FIELD_W];
                    last_next = s_axis_tlast;
                    ovf_next  = next_position_reg >= gbs_pkg::POS_W'(MAX_BOXES);
                    keep_next = 1'b0;
                    // skip the compare loop for a box past store capacity
                    state_next = (next_position_reg >= gbs_pkg::POS_W'(MAX_BOXES))
                                 ? S_FIN : S_AREA;
                end
            end
            S_AREA: begin
                prod_next  = mul_prod;
                state_next = S_AREA_W;
            end
            S_AREA_W: begin
                area_n_next = prod_reg[IW-1:0];
                idx_next    = '0;
                if (kept_count_reg == '0) begin
                    keep_next  = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_INT;
            end
            S_INT: begin
                prod_next  = mul_prod;
                state_next = S_KAREA;
            end
            S_KAREA: begin
                inter_next = prod_reg[IW-1:0];
                prod_next  = mul_prod;
                state_next = S_UNION;
            end
            S_UNION: begin
                union_next = MA'(area_n_reg) + MA'(prod_reg[IW-1:0]) - MA'(inter_reg);
                state_next = S_THR;
            end
            S_THR: begin
                prod_next  = mul_prod;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (over_thr) begin
                    keep_next  = 1'b0;
                    state_next = S_FIN;
                end else if ((CNT_W'(idx_reg) + CNT_W'(1)) == kept_count_reg) begin
                    keep_next  = 1'b1;
                    state_next = S_FIN;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_FIN: begin
                // store write happens this cycle when kept; advance counters, or clear them at the set end
                res_index_next  = next_position_reg[gbs_pkg::INDEX_W-1:0];
                res_total_next  = gbs_pkg::TOTAL_W'(kept_count_reg + CNT_W'(keep_reg));
                if (last_reg) begin
                    kept_count_next    = '0;
                    next_position_next = '0;
                end else begin
                    kept_count_next = kept_count_reg + CNT_W'(keep_reg);
                    if (next_position_reg != '1) begin
                        next_position_next = next_position_reg + gbs_pkg::POS_W'(1);
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[gbs_pkg::OUT_INDEX_LSB +: gbs_pkg::INDEX_W] = res_index_reg;
                    m_data_next[gbs_pkg::OUT_KEEP_BIT] = keep_reg;
                    m_data_next[gbs_pkg::OUT_TOTAL_LSB +: gbs_pkg::TOTAL_W] = res_total_reg;
                    m_data_next[gbs_pkg::OUT_OVF_BIT]  = ovf_reg;
                    m_last_next  = last_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            kept_count_reg    <= '0;
            next_position_reg <= '0;
            thr_reg           <= gbs_pkg::THR_RESET;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            kept_count_reg    <= kept_count_next;
            next_position_reg <= next_position_next;
            thr_reg           <= thr_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bx1_reg       <= bx1_next;
        by1_reg       <= by1_next;
        bx2_reg       <= bx2_next;
        by2_reg       <= by2_next;
        last_reg      <= last_next;
        ovf_reg       <= ovf_next;
        keep_reg      <= keep_next;
        idx_reg       <= idx_next;
        prod_reg      <= prod_next;
        area_n_reg    <= area_n_next;
        inter_reg     <= inter_next;
        union_reg     <= union_next;
        res_index_reg <= res_index_next;
        res_total_reg <= res_total_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

`ifndef SYNTH
    // one item at a time: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while sequencer busy");

    // an overflow box is never kept
    a_keep_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[gbs_pkg::OUT_KEEP_BIT]
                            && m_axis_tdata[gbs_pkg::OUT_OVF_BIT]))
        else $error("result both kept and overflowed");

    // kept boxes never outnumber boxes seen
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        gbs_pkg::POS_W'(kept_count_reg) <= next_position_reg)
        else $error("kept count above position");

    // store write only for an in-range box
    a_store_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (!ovf_reg && (kept_count_reg < CNT_W'(MAX_BOXES))))
        else $error("store write past capacity");
`endif

endmodule

[rtl/gbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the kept-box store of the suppression block.
module gbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
